// ----- src/rhsl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_pkg
// Shared widths and defaults for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhsl_pkg;

    // default number of fraction bits on hue, saturation and lightness
    localparam int FRAC_BITS_DEF = 16;

    // width of one colour component
    localparam int COMP_W = 8;

    // input request: red, green, blue packed from the lowest bit up
    localparam int IN_TDATA_W = 3 * COMP_W;

    // numerator and denominator width of the divider (6 * 255 fits 11 bits)
    localparam int DIV_W = 11;

    // quotient bits resolved in each divider stage
    localparam int DIV_STEPS = 2;

endpackage
`default_nettype wire

// ----- src/rhsl_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_div
// Pipelined restoring divider for num / den with num <= den. Produces the
// quotient rounded to the nearest step of 2^-FRAC_BITS, a tie rounded up.
// ----------------------------------------------------------------------------
module rhsl_div #(
    parameter int FRAC_BITS = rhsl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_ce,
    input  wire logic [rhsl_pkg::DIV_W-1:0]  i_num,
    input  wire logic [rhsl_pkg::DIV_W-1:0]  i_den,
    output logic      [FRAC_BITS:0]          o_quo
);

    // one integer step, then FRAC_BITS + 1 fraction steps (one for rounding)
    localparam int NSTEP = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 2;
    localparam int NS    = (NSTEP + rhsl_pkg::DIV_STEPS - 1) / rhsl_pkg::DIV_STEPS;
    localparam int DW    = rhsl_pkg::DIV_W;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [QW-1:0] r_quo [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [DW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (s == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign den_in = r_den[s-1];
                assign quo_in = r_quo[s-1];
            end

            always_comb begin
                logic [DW:0] t;
                t     = '0;
                n_rem = rem_in;
                n_quo = quo_in;
                for (int j = 0; j < rhsl_pkg::DIV_STEPS; j++) begin
                    if (s * rhsl_pkg::DIV_STEPS + j < NSTEP) begin
                        // the integer step compares without a shift
                        if (s * rhsl_pkg::DIV_STEPS + j == 0) begin
                            t = {1'b0, n_rem};
                        end else begin
                            t = {n_rem, 1'b0};
                        end
                        if (t >= {1'b0, den_in}) begin
                            t     = t - {1'b0, den_in};
                            n_quo = {n_quo[QW-2:0], 1'b1};
                        end else begin
                            n_quo = {n_quo[QW-2:0], 1'b0};
                        end
                        n_rem = t[DW-1:0];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                    r_quo[s] <= n_quo;
                end
            end
        end
    endgenerate

    // round: halve the quotient that carries one extra bit, adding one first
    logic [QW:0] w_round;
    assign w_round = {1'b0, r_quo[NS-1]} + {{QW{1'b0}}, 1'b1};
    assign o_quo   = w_round[FRAC_BITS+1:1];

endmodule
`default_nettype wire

// ----- src/rgb_to_hsl_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Streaming RGB to HSL conversion, one pixel per clock while the skid register is empty.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB pixel per clock while the skid register is empty and
// returns hue (Q0.FRAC_BITS, in turns), saturation and lightness
// (Q1.FRAC_BITS) rounded to the nearest step, plus an achromatic flag in
// tuser for grey pixels (hue and saturation then read zero). Throughput is
// one pixel per clock while the skid register is empty. Three stages find
// max, min, spread, hue numerator and lightness, then two dividers resolve
// two quotient bits per stage for hue and saturation while the lightness
// rides alongside, and an output register holds the rounded result. A skid
// register behind the output catches a result when the output side stalls,
// and input requests stop only once it is full.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
    parameter  int FRAC_BITS   = rhsl_pkg::FRAC_BITS_DEF,
    localparam int OUT_TDATA_W = ((3 * FRAC_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave side
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [rhsl_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // master side
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // hue [F-1:0], saturation [2F:F], lightness [3F+1:2F+1], zeros above
    output logic      [OUT_TDATA_W-1:0]          o_m_axis_tdata,
    // achromatic [0]
    output logic      [0:0]                      o_m_axis_tuser
);

    localparam int CW    = rhsl_pkg::COMP_W;
    localparam int DW    = rhsl_pkg::DIV_W;
    localparam int OUT_W = 3 * FRAC_BITS + 2;
    localparam int NS    = (FRAC_BITS + 2 + rhsl_pkg::DIV_STEPS - 1) / rhsl_pkg::DIV_STEPS;
    localparam int REP   = (FRAC_BITS + CW - 1) / CW;

    // which component holds the maximum (red tested first, then green)
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [CW:0]   FULL_SCALE = (CW + 1)'(255);
    localparam logic [CW:0]   TWO_FULL   = (CW + 1)'(510);

    logic w_ce;

    // ------------------------------------------------------------------
    // stage 1: maximum, minimum and which component wins
    // ------------------------------------------------------------------
    logic [CW-1:0] w_red, w_green, w_blue;
    logic [CW-1:0] n1_max, n1_min;
    logic [1:0]    n1_sel;

    assign w_red   = i_s_axis_tdata[CW-1:0];
    assign w_green = i_s_axis_tdata[2*CW-1:CW];
    assign w_blue  = i_s_axis_tdata[3*CW-1:2*CW];

    always_comb begin
        if (w_red >= w_green && w_red >= w_blue) begin
            n1_sel = SEL_RED;
            n1_max = w_red;
        end else if (w_green >= w_blue) begin
            n1_sel = SEL_GREEN;
            n1_max = w_green;
        end else begin
            n1_sel = SEL_BLUE;
            n1_max = w_blue;
        end
        n1_min = w_red;
        if (w_green < n1_min) n1_min = w_green;
        if (w_blue < n1_min) n1_min = w_blue;
    end

    logic          r1_valid;
    logic [CW-1:0] r1_red, r1_green, r1_blue, r1_max, r1_min;
    logic [1:0]    r1_sel;

    // ------------------------------------------------------------------
    // stage 2: sum, spread and the signed difference for the hue
    // ------------------------------------------------------------------
    logic [CW:0]   n2_sum;
    logic [CW-1:0] n2_d;
    logic [CW:0]   n2_diff;

    assign n2_sum = {1'b0, r1_max} + {1'b0, r1_min};
    assign n2_d   = r1_max - r1_min;

    always_comb begin
        case (r1_sel)
            SEL_RED:   n2_diff = {1'b0, r1_green} - {1'b0, r1_blue};
            SEL_GREEN: n2_diff = {1'b0, r1_blue} - {1'b0, r1_red};
            SEL_BLUE:  n2_diff = {1'b0, r1_red} - {1'b0, r1_green};
            default:   n2_diff = '0;
        endcase
    end

    logic          r2_valid;
    logic [CW:0]   r2_sum;
    logic [CW-1:0] r2_d;
    logic [CW:0]   r2_diff;
    logic [1:0]    r2_sel;

    // ------------------------------------------------------------------
    // stage 3: hue numerator wrapped into [0, 6d), saturation denominator,
    // lightness
    // ------------------------------------------------------------------
    logic [DW-1:0] n3_den6;
    logic [DW-1:0] w_base;
    logic [DW:0]   w_num_raw;
    logic [DW-1:0] n3_num;
    logic [CW-1:0] n3_sden;

    assign n3_den6 = {1'b0, r2_d, 2'b00} + {2'b00, r2_d, 1'b0};

    always_comb begin
        case (r2_sel)
            SEL_GREEN: w_base = {2'b00, r2_d, 1'b0};
            SEL_BLUE:  w_base = {1'b0, r2_d, 2'b00};
            default:   w_base = '0;
        endcase
        w_num_raw = {1'b0, w_base} + {{(DW - CW){r2_diff[CW]}}, r2_diff};
        // wrap a negative hue by one turn
        if (w_num_raw[DW]) begin
            w_num_raw = w_num_raw + {1'b0, n3_den6};
        end
        n3_num = w_num_raw[DW-1:0];
    end

    always_comb begin
        if (r2_sum < FULL_SCALE) begin
            n3_sden = r2_sum[CW-1:0];
        end else begin
            n3_sden = CW'(TWO_FULL - r2_sum);
        end
    end

    // sum / 510 = a / 2 + b / 510 with sum = 255a + b and b below 255;
    // b / 255 is b repeated in binary, so its leading bits come from copies
    logic [1:0]            w_light_int;
    logic [CW-1:0]         w_light_rem;
    logic [REP*CW-1:0]     w_light_rep;
    logic [FRAC_BITS-1:0]  w_light_step;
    logic [FRAC_BITS:0]    n3_light;

    always_comb begin
        if (r2_sum >= TWO_FULL) begin
            w_light_int = 2'd2;
            w_light_rem = '0;
        end else if (r2_sum >= FULL_SCALE) begin
            w_light_int = 2'd1;
            w_light_rem = CW'(r2_sum - FULL_SCALE);
        end else begin
            w_light_int = 2'd0;
            w_light_rem = r2_sum[CW-1:0];
        end
        w_light_rep  = {REP{w_light_rem}};
        // b never reaches 255, so the leading bits are never all ones
        w_light_step = w_light_rep[REP*CW-1 -: FRAC_BITS] + FRAC_BITS'(1);
        n3_light     = {w_light_int, w_light_step[FRAC_BITS-1:1]};
    end

    logic               r3_valid;
    logic               r3_grey;
    logic [DW-1:0]      r3_num, r3_den6;
    logic [CW-1:0]      r3_d, r3_sden;
    logic [FRAC_BITS:0] r3_light;

    // ------------------------------------------------------------------
    // pipeline registers of the front stages
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_ce) begin
            r1_valid <= i_s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_red   <= w_red;
            r1_green <= w_green;
            r1_blue  <= w_blue;
            r1_max   <= n1_max;
            r1_min   <= n1_min;
            r1_sel   <= n1_sel;
            r2_sum   <= n2_sum;
            r2_d     <= n2_d;
            r2_diff  <= n2_diff;
            r2_sel   <= r1_sel;
            r3_num   <= n3_num;
            r3_den6  <= n3_den6;
            r3_d     <= r2_d;
            r3_sden  <= n3_sden;
            r3_light <= n3_light;
            r3_grey  <= (r2_d == '0);
        end
    end

    // ------------------------------------------------------------------
    // dividers and the matching valid / grey / lightness delay line
    // ------------------------------------------------------------------
    logic [FRAC_BITS:0] w_hue_q, w_sat_q;

    rhsl_div #(.FRAC_BITS(FRAC_BITS)) u_div_hue (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r3_num),
        .i_den (r3_den6),
        .o_quo (w_hue_q)
    );

    rhsl_div #(.FRAC_BITS(FRAC_BITS)) u_div_sat (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({{(DW - CW){1'b0}}, r3_d}),
        .i_den ({{(DW - CW){1'b0}}, r3_sden}),
        .o_quo (w_sat_q)
    );

    logic [NS-1:0]      r_dv, r_dg;
    logic [FRAC_BITS:0] r_dl [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_ce) begin
            r_dv <= {r_dv[NS-2:0], r3_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dg    <= {r_dg[NS-2:0], r3_grey};
            r_dl[0] <= r3_light;
            for (int k = 1; k < NS; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // result: drop a hue of a full turn, zero hue and saturation on grey
    // ------------------------------------------------------------------
    logic                 w_grey;
    logic [FRAC_BITS-1:0] w_hue;
    logic [FRAC_BITS:0]   w_sat;
    logic [OUT_W-1:0]     w_res;

    assign w_grey = r_dg[NS-1];
    assign w_hue  = (w_grey || w_hue_q[FRAC_BITS]) ? '0 : w_hue_q[FRAC_BITS-1:0];
    assign w_sat  = w_grey ? '0 : w_sat_q;
    assign w_res  = {r_dl[NS-1], w_sat, w_hue};

    // ------------------------------------------------------------------
    // output register with a skid register behind it
    // ------------------------------------------------------------------
    logic             r_out_valid, r_sk_valid;
    logic [OUT_W-1:0] r_out_data, r_sk_data;
    logic             r_out_grey, r_sk_grey;
    logic             w_push, w_take;

    assign w_ce   = !r_sk_valid;
    assign w_push = w_ce && r_dv[NS-1];
    assign w_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            // hold the pipe; refill the output from the skid when taken
            if (w_take) begin
                r_sk_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_sk_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (w_take) begin
                r_out_data <= r_sk_data;
                r_out_grey <= r_sk_grey;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= w_res;
                r_out_grey <= w_grey;
            end else begin
                r_sk_data <= w_res;
                r_sk_grey <= w_grey;
            end
        end
    end

    assign o_s_axis_tready = w_ce;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_grey;

endmodule
`default_nettype wire

// ----- bench/rgb_to_hsl_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_test
// Self-checking bench for the streaming RGB to HSL converter.
// ----------------------------------------------------------------------------
// Feeds corner pixels first: black, white, primaries, component ties, greys
// and pixels around the saturation switch point. It then feeds random
// pixels, biased towards greys, ties and extreme component values. Each
// accepted request is converted by an exact integer model of the conversion
// and queued. Each result is compared field by field with the oldest queued
// conversion. Random gaps on the input side and stalls on the output side
// are applied, except in the last stretch of the run.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_test;

    localparam int FRAC     = rhsl_pkg::FRAC_BITS_DEF;
    localparam int OUT_W    = ((3 * FRAC + 2 + 7) / 8) * 8;
    localparam int N_RANDOM = 1830;
    localparam int N_QUIET  = 150;
    localparam int LIMIT    = 5000;
    localparam int TAIL     = 32;

    typedef struct {
        logic [FRAC-1:0] hue;
        logic [FRAC:0]   sat;
        logic [FRAC:0]   light;
        logic            grey;
    } t_hsl;

    class t_hsl_scoreboard;
        t_hsl pending_hsl[$];
        int   mismatches;
        int   pixels_in;
        int   greys_in;
        int   results_out;

        // nearest step of num/den, a tie rounded up
        function automatic longint unsigned round_ratio(longint unsigned num,
                                                        longint unsigned den);
            return ((num << FRAC) * 2 + den) / (den * 2);
        endfunction

        function automatic t_hsl convert_pixel(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
            t_hsl            res;
            longint          rr, gg, bb, mx, mn, sum, spread, turn, sden;
            longint unsigned hq;
            rr  = longint'(r);
            gg  = longint'(g);
            bb  = longint'(b);
            mx  = rr;
            mn  = rr;
            if (gg > mx) mx = gg;
            if (bb > mx) mx = bb;
            if (gg < mn) mn = gg;
            if (bb < mn) mn = bb;
            sum    = mx + mn;
            spread = mx - mn;
            res.light = (FRAC + 1)'(round_ratio(sum, 510));
            res.grey  = (spread == 0);
            res.hue   = '0;
            res.sat   = '0;
            if (!res.grey) begin
                sden = (sum < 255) ? sum : 510 - sum;
                if (sden != 0) res.sat = (FRAC + 1)'(round_ratio(spread, sden));
                // red wins ties over green, green over blue
                if (rr == mx) turn = gg - bb;
                else if (gg == mx) turn = 2 * spread + bb - rr;
                else turn = 4 * spread + rr - gg;
                if (turn < 0) turn += 6 * spread;
                hq = round_ratio(turn, 6 * spread);
                // wrap a full turn to zero
                res.hue = (hq >= (64'd1 << FRAC)) ? '0 : hq[FRAC-1:0];
            end
            return res;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_hsl res;
            res = convert_pixel(r, g, b);
            pending_hsl.push_back(res);
            pixels_in++;
            if (res.grey) greys_in++;
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic grey);
            t_hsl want;
            logic [FRAC-1:0] hue;
            logic [FRAC:0]   sat, light;
            results_out++;
            if (pending_hsl.size() == 0) begin
                $error("result with no request outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            want  = pending_hsl.pop_front();
            hue   = data[FRAC-1:0];
            sat   = data[2*FRAC:FRAC];
            light = data[3*FRAC+1:2*FRAC+1];
            if (hue !== want.hue) begin
                $error("hue: expected %0d, got %0d", want.hue, hue);
                mismatches++;
            end
            if (sat !== want.sat) begin
                $error("saturation: expected %0d, got %0d", want.sat, sat);
                mismatches++;
            end
            if (light !== want.light) begin
                $error("lightness: expected %0d, got %0d", want.light, light);
                mismatches++;
            end
            if (grey !== want.grey) begin
                $error("achromatic: expected %0d, got %0d", want.grey, grey);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic [23:0]      i_s_axis_tdata  = '0;
    logic             i_m_axis_tready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [0:0]       o_m_axis_tuser;

    t_hsl_scoreboard scoreboard = new();
    bit            quiet      = 1'b0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    rgb_to_hsl_converter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // output side: check results, stall in bursts, count idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                scoreboard.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) ||
                (i_s_axis_tvalid && o_s_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = int'($urandom_range(1, 8)) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (idle_cycles >= LIMIT);
        $display("timeout: no request or result moved for %0d cycles", LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            gap = int'($urandom_range(1, 8));
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        scoreboard.note_pixel(r, g, b);
    endtask

    function automatic logic [7:0] pick_extreme();
        logic [7:0] vals[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        return vals[$urandom_range(0, 5)];
    endfunction

    initial begin
        logic [23:0] corners[] = '{
            24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
            24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h808080, 24'h7F7F7F,
            24'h010000, 24'hFFFFFE, 24'h80007F, 24'h7F0080, 24'h01FFFF,
            24'h0100FF, 24'h00FF01, 24'h7F7F80, 24'h807F7F, 24'hFEFFFF,
            24'h3030C0, 24'hC03030, 24'h30C030, 24'h010101
        };
        logic [7:0] r, g, b, v;
        int         kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tdata packs red low, blue high
        foreach (corners[i]) begin
            send_pixel(corners[i][7:0], corners[i][15:8], corners[i][23:16]);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
            r    = 8'($urandom_range(0, 255));
            g    = 8'($urandom_range(0, 255));
            b    = 8'($urandom_range(0, 255));
            v    = 8'($urandom_range(0, 255));
            kind = int'($urandom_range(0, 9));
            case (kind)
                0: begin
                    r = v; g = v; b = v;
                end
                1: begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                2: begin
                    r = pick_extreme(); g = pick_extreme(); b = pick_extreme();
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        i_s_axis_tvalid <= 1'b0;

        while (scoreboard.pending_hsl.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("Converted %0d pixels (%0d grey): corner colours, then random",
                 scoreboard.pixels_in, scoreboard.greys_in);
        $display("colours with input gaps and output stalls; %0d results checked.",
                 scoreboard.results_out);
        if (scoreboard.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- rgb_to_hsl_converter.f -----
src/rhsl_pkg.sv
src/rhsl_div.sv
src/rgb_to_hsl_converter.sv
bench/rgb_to_hsl_converter_test.sv
